>>> design/uart_8n1_transceiver_top_assert.svh
// Assertion macros for the UART transceiver top level.
// Depends on nothing; included by uart_8n1_transceiver_top.sv.
`ifndef UART_8N1_TRANSCEIVER_TOP_ASSERT_SVH
`define UART_8N1_TRANSCEIVER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define U8T_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define U8T_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/u8t_pkg.sv
// Shared types and constants for the UART transceiver.
// Depends on nothing; used by the transmitter, receiver and top level.
package u8t_pkg;

   localparam int RX_BYTE_W = 8;
   localparam int TX_BYTE_W = 8;
   localparam int PERIOD_W  = 16;

   localparam logic [1:0] CSR_BIT_PERIOD = 2'd0;
   localparam logic [1:0] CSR_TX_ENABLE  = 2'd1;
   localparam logic [1:0] CSR_RX_ENABLE  = 2'd2;

   localparam logic [PERIOD_W-1:0] BIT_PERIOD_RESET = 16'd833;

   typedef enum logic [3:0] {
      RX_IDLE  = 4'b0001,
      RX_START = 4'b0010,
      RX_DATA  = 4'b0100,
      RX_STOP  = 4'b1000
   } rx_phase_type;

   typedef struct packed {
      logic line;
      logic busy;
   } tx_status_type;

   typedef struct packed {
      logic                 valid;
      logic [RX_BYTE_W-1:0] data;
      logic                 frame_error;
   } rx_result_type;

endpackage

>>> design/u8t_tx.sv
// UART transmitter: start bit, data bits LSB first, two stop bits.
// Depends on u8t_pkg; advances one tick per step.
module u8t_tx
   import u8t_pkg::*;
#(
   parameter int DATA_BITS   = 8,
   parameter int TIMER_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic                   tx_enable,
   input  logic [TIMER_WIDTH-1:0] period,
   input  logic                   request,
   input  logic [TX_BYTE_W-1:0]   tx_byte,
   output tx_status_type          status
);

   localparam int SHIFT_W = DATA_BITS + 2;
   localparam int LEFT_W  = $clog2(DATA_BITS + 4);

   logic [SHIFT_W-1:0]     shift_ff, shift_in;
   logic [LEFT_W-1:0]      left_ff, left_in, left_dec;
   logic [TIMER_WIDTH-1:0] count_ff, count_in;
   logic                   level_ff, level_in;
   logic [TIMER_WIDTH:0]   count_inc;
   logic [15:0]            byte_ext;

   always_comb begin
      shift_in  = shift_ff;
      left_in   = left_ff;
      count_in  = count_ff;
      level_in  = level_ff;
      byte_ext  = {8'd0, tx_byte};
      count_inc = {1'b0, count_ff} + {{TIMER_WIDTH{1'b0}}, 1'b1};
      left_dec  = left_ff - LEFT_W'(1);
      if (left_ff == '0) begin
         if (tx_enable && request) begin
            shift_in = {2'b11, byte_ext[DATA_BITS-1:0]};
            left_in  = LEFT_W'(DATA_BITS + 3);
            count_in = '0;
            level_in = 1'b0;
         end
      end else if (count_inc >= {1'b0, period}) begin
         count_in = '0;
         left_in  = left_dec;
         if (left_dec != '0) begin
            level_in = shift_ff[0];
            shift_in = shift_ff >> 1;
         end else begin
            level_in = 1'b1;
         end
      end else begin
         count_in = count_inc[TIMER_WIDTH-1:0];
      end
      status.line = level_in;
      status.busy = (left_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= '0;
         left_ff  <= '0;
         count_ff <= '0;
         level_ff <= 1'b1;
      end else if (step) begin
         shift_ff <= shift_in;
         left_ff  <= left_in;
         count_ff <= count_in;
         level_ff <= level_in;
      end
   end

endmodule

>>> design/u8t_rx.sv
// UART receiver: mid-bit sampling of data bits and stop bit check.
// Depends on u8t_pkg; advances one tick per step.
module u8t_rx
   import u8t_pkg::*;
#(
   parameter int DATA_BITS   = 8,
   parameter int TIMER_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic                   rx_enable,
   input  logic [TIMER_WIDTH-1:0] period,
   input  logic                   rx_line,
   output rx_result_type          result
);

   localparam int IDX_W = $clog2(DATA_BITS + 1);

   rx_phase_type           phase_ff, phase_in;
   logic [TIMER_WIDTH-1:0] count_ff, count_in, length;
   logic [RX_BYTE_W-1:0]   shift_ff, shift_in;
   logic [IDX_W-1:0]       index_ff, index_in;
   logic [TIMER_WIDTH:0]   count_inc;
   logic                   done;

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      shift_in  = shift_ff;
      index_in  = index_ff;
      result    = '0;
      length    = (phase_ff == RX_START) ? (period >> 1) : period;
      count_inc = {1'b0, count_ff} + {{TIMER_WIDTH{1'b0}}, 1'b1};
      done      = (count_inc >= {1'b0, length});
      if (phase_ff != RX_IDLE) begin
         count_in = done ? '0 : count_inc[TIMER_WIDTH-1:0];
      end
      unique case (phase_ff)
         RX_IDLE: begin
            if (rx_enable && !rx_line) begin
               phase_in = RX_START;
               count_in = '0;
               shift_in = '0;
               index_in = '0;
            end
         end
         RX_START: begin
            if (done) begin
               phase_in = RX_DATA;
            end
         end
         RX_DATA: begin
            if (done) begin
               if ((32'(index_ff) < DATA_BITS) && (32'(index_ff) < RX_BYTE_W)) begin
                  shift_in[index_ff[2:0]] = shift_ff[index_ff[2:0]] | rx_line;
               end
               index_in = index_ff + IDX_W'(1);
               if (32'(index_in) >= DATA_BITS) begin
                  phase_in = RX_STOP;
               end
            end
         end
         default: begin
            if (done) begin
               if (rx_line) begin
                  result.valid = 1'b1;
                  result.data  = shift_ff;
               end else begin
                  result.frame_error = 1'b1;
               end
               phase_in = RX_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= RX_IDLE;
         count_ff <= '0;
         shift_ff <= '0;
         index_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         shift_ff <= shift_in;
         index_ff <= index_in;
      end
   end

endmodule

>>> design/uart_8n1_transceiver_top.sv
// Top level of the full-duplex UART transceiver: registers, cores, result register.
// Depends on u8t_pkg, u8t_tx, u8t_rx and uart_8n1_transceiver_top_assert.svh.
//
// Channel   Direction  Handshake                Contents
// req       in         req_valid / req_ready    rx_line, tx_request, tx_byte
// rsp       out        rsp_valid / rsp_ready    tx_line, tx_busy, rx_valid, rx_byte, frame_error
// csr       in         csr_write_enable         csr_index, csr_write_data
//
// Each req transfer is one line tick; its rsp item appears in the result register
// in the next cycle, and one item can be taken every cycle while rsp_ready is high.
// req_ready is low only while the result register is full and rsp_ready is low.
// Synchronous reset loads the register defaults and idles both cores.
`include "uart_8n1_transceiver_top_assert.svh"

module uart_8n1_transceiver_top
   import u8t_pkg::*;
#(
   parameter int DATA_BITS   = 8,
   parameter int TIMER_WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_rx_line,
   input  logic                 req_tx_request,
   input  logic [TX_BYTE_W-1:0] req_tx_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_tx_line,
   output logic                 rsp_tx_busy,
   output logic                 rsp_rx_valid,
   output logic [RX_BYTE_W-1:0] rsp_rx_byte,
   output logic                 rsp_frame_error,
   input  logic                 csr_write_enable,
   input  logic [1:0]           csr_index,
   input  logic [PERIOD_W-1:0]  csr_write_data
);

   logic [PERIOD_W-1:0]    bit_period_ff;
   logic                   tx_enable_ff, rx_enable_ff;
   logic [31:0]            period_ext;
   logic [TIMER_WIDTH-1:0] period;
   logic                   step;
   tx_status_type          tx_status;
   rx_result_type          rx_result;
   logic                   rsp_valid_ff, rsp_valid_in;
   tx_status_type          tx_status_ff;
   rx_result_type          rx_result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_period_ff <= BIT_PERIOD_RESET;
         tx_enable_ff  <= 1'b1;
         rx_enable_ff  <= 1'b1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_BIT_PERIOD: bit_period_ff <= csr_write_data;
            CSR_TX_ENABLE:  tx_enable_ff  <= csr_write_data[0];
            CSR_RX_ENABLE:  rx_enable_ff  <= csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   assign period_ext = {16'd0, bit_period_ff};
   assign period     = period_ext[TIMER_WIDTH-1:0];
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign step       = req_valid && req_ready;

   u8t_tx #(
      .DATA_BITS   (DATA_BITS),
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_tx (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .tx_enable (tx_enable_ff),
      .period    (period),
      .request   (req_tx_request),
      .tx_byte   (req_tx_byte),
      .status    (tx_status)
   );

   u8t_rx #(
      .DATA_BITS   (DATA_BITS),
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_rx (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .rx_enable (rx_enable_ff),
      .period    (period),
      .rx_line   (req_rx_line),
      .result    (rx_result)
   );

   always_comb begin
      priority if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         tx_status_ff <= tx_status;
         rx_result_ff <= rx_result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_tx_line     = tx_status_ff.line;
   assign rsp_tx_busy     = tx_status_ff.busy;
   assign rsp_rx_valid    = rx_result_ff.valid;
   assign rsp_rx_byte     = rx_result_ff.data;
   assign rsp_frame_error = rx_result_ff.frame_error;

   `U8T_ASSERT_NEXT(a_step_gives_result, clock, reset, step, rsp_valid,
      "accepted tick did not produce a result")
   `U8T_ASSERT_SAME(a_byte_zero_when_not_valid, clock, reset,
      rsp_valid && !rsp_rx_valid, rsp_rx_byte == '0,
      "received byte nonzero without rx_valid")
   `U8T_ASSERT_SAME(a_valid_excludes_error, clock, reset, rsp_valid,
      !(rsp_rx_valid && rsp_frame_error), "rx_valid and frame_error together")
   `U8T_ASSERT_SAME(a_idle_line_high, clock, reset, rsp_valid && !rsp_tx_busy,
      rsp_tx_line, "transmit line low while transmitter idle")

endmodule
